// ===== src/tbiw_pkg.sv =====
// ---------------------------------------------------------------------------
// tbiw_pkg: shared types and constants for the bracket/weight unit
// Field widths, item kinds and the front-to-back queue entry.
// ---------------------------------------------------------------------------
package tbiw_pkg;

  localparam int AgeEntriesDef   = 256;
  localparam int MetalEntriesDef = 8;
  localparam int FracBitsDef     = 16;
  localparam int TimeFrac        = 16;
  localparam int MetalFrac       = 24;
  localparam logic [31:0] Log10Two = 32'd1292913986;
  localparam logic [16:0] WeightOne = 17'h10000;

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_AGE   = 2'd1;
  localparam logic [1:0] KIND_METAL = 2'd2;

  localparam logic CFG_AGE_COUNT   = 1'b0;
  localparam logic CFG_METAL_COUNT = 1'b1;

  // query handed from front to back
  typedef struct packed {
    logic        age_pos;   // time_now > time_target
    logic [31:0] age_val;   // time difference
    logic        met_nz;
    logic [23:0] met_val;
  } query_t;

endpackage

// ===== src/tbiw_front.sv =====
// ---------------------------------------------------------------------------
// tbiw_front: input front end
// Accepts items, performs table loads, pushes queries into a small queue.
// ---------------------------------------------------------------------------
module tbiw_front #(
  parameter int AGE_ENTRIES   = tbiw_pkg::AgeEntriesDef,
  parameter int METAL_ENTRIES = tbiw_pkg::MetalEntriesDef,
  parameter int AW = $clog2(AGE_ENTRIES),
  parameter int MW = $clog2(METAL_ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            kind,
  input  logic [7:0]            entry_index,
  input  logic signed [23:0]    entry_value,
  input  logic [31:0]           time_now,
  input  logic [31:0]           time_target,
  input  logic [23:0]           metallicity,
  output logic                  age_we,
  output logic [AW-1:0]         age_wa,
  output logic                  met_we,
  output logic [MW-1:0]         met_wa,
  output logic signed [23:0]    wr_data,
  output logic                  q_valid,
  input  logic                  q_ready,
  output tbiw_pkg::query_t      q_data
);
  import tbiw_pkg::*;

  // two-entry queue
  query_t   fifo_r [2];
  logic     wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic     acc, push, pop;
  logic     is_load;
  query_t   qn;

  // a load waits until no earlier query is queued or in the back end
  assign is_load  = (kind == KIND_AGE) || (kind == KIND_METAL);
  assign in_ready = (cnt_r != 2'd2) && !(is_load && !(cnt_r == 2'd0 && q_ready));
  assign acc  = in_valid && in_ready;
  assign push = acc && (kind == KIND_QUERY);
  assign pop  = q_valid && q_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = fifo_r[rp_r];

  assign age_we  = acc && (kind == KIND_AGE) && ({24'd0, entry_index} < 32'(AGE_ENTRIES));
  assign met_we  = acc && (kind == KIND_METAL) && ({24'd0, entry_index} < 32'(METAL_ENTRIES));
  assign age_wa  = AW'({24'd0, entry_index});
  assign met_wa  = MW'({24'd0, entry_index});
  assign wr_data = entry_value;

  always_comb begin
    qn.age_pos = time_now > time_target;
    qn.age_val = time_now - time_target;
    qn.met_nz  = metallicity != 24'd0;
    qn.met_val = metallicity;
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
    if (push) fifo_r[wp_r] <= qn;
  end
endmodule

// ===== src/tbiw_back.sv =====
// ---------------------------------------------------------------------------
// tbiw_back: query engine
// Shared log unit, sequential bracket search and shared restoring divider.
// ---------------------------------------------------------------------------
module tbiw_back #(
  parameter int AGE_ENTRIES   = tbiw_pkg::AgeEntriesDef,
  parameter int METAL_ENTRIES = tbiw_pkg::MetalEntriesDef,
  parameter int FRAC_BITS     = tbiw_pkg::FracBitsDef,
  parameter int AW = $clog2(AGE_ENTRIES),
  parameter int MW = $clog2(METAL_ENTRIES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  tbiw_pkg::query_t   q_data,
  input  logic               age_we,
  input  logic [AW-1:0]      age_wa,
  input  logic               met_we,
  input  logic [MW-1:0]      met_wa,
  input  logic signed [23:0] wr_data,
  input  logic [8:0]         age_count,
  input  logic [3:0]         metal_count,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [7:0]         res_age_index,
  output logic [2:0]         res_metal_index,
  output logic [16:0]        res_aw_lo,
  output logic [16:0]        res_aw_hi,
  output logic [16:0]        res_mw_lo,
  output logic [16:0]        res_mw_hi
);
  import tbiw_pkg::*;

  localparam int GB = FRAC_BITS + 4;          // log2 fraction bits
  localparam int LS = GB + 32 - FRAC_BITS;    // final shift
  localparam int LW = GB + 8;                 // signed log2 width
  localparam int PW = LW + 32;                // product width

  localparam logic [3:0] S_IDLE = 4'd0, S_NORM = 4'd1, S_SQR = 4'd2, S_MUL = 4'd3,
    S_RND = 4'd4, S_ENDS = 4'd5, S_CLS = 4'd6, S_SRCH = 4'd7, S_SRCHW = 4'd8,
    S_DIV = 4'd9, S_NEXT = 4'd10, S_OUT = 4'd11, S_MUL2 = 4'd12;

  logic signed [23:0] age_mem [AGE_ENTRIES];
  logic signed [23:0] met_mem [METAL_ENTRIES];
  logic [AW-1:0] ara;
  logic [MW-1:0] mra;
  logic signed [23:0] ard_r, mrd_r;

  always_ff @(posedge clk) begin
    if (age_we) age_mem[age_wa] <= wr_data;
    if (met_we) met_mem[met_wa] <= wr_data;
    ard_r <= age_mem[ara];
    mrd_r <= met_mem[mra];
  end

  logic [3:0]  st_r;
  logic        pass_r;               // 0 age, 1 metal
  query_t      q_r;
  logic [31:0] v_r;
  logic [5:0]  p_r;
  logic [31:0] m_r;
  logic [GB-1:0] f_r;
  logic [5:0]  it_r;
  logic [63:0] sq_r;
  logic signed [LW-1:0] lg_r;
  logic [PW-1:0] prod_r;
  logic signed [24:0] x_r;           // log value
  logic [9:0]  k_r, n_r;
  logic signed [23:0] lo_r, hi_r;
  logic [1:0]  ph_r;
  logic [16:0] fr_r;
  logic [40:0] rem_r;
  logic [24:0] den_r;
  logic [4:0]  dc_r;
  logic [7:0]  ai_r;
  logic [2:0]  mi_r;
  logic [16:0] aw1_r, aw2_r, mw1_r, mw2_r;
  logic        ov_r;

  logic [5:0] msb;
  always_comb begin
    msb = 6'd0;
    for (int i = 0; i < 32; i++) if (v_r[i]) msb = 6'(i);
  end

  logic [9:0] na, nm, ncur;
  always_comb begin
    na = {1'b0, age_count};
    if (na < 10'd3) na = 10'd3;
    if (na > 10'(AGE_ENTRIES)) na = 10'(AGE_ENTRIES);
    nm = {6'd0, metal_count};
    if (nm < 10'd2) nm = 10'd2;
    if (nm > 10'(METAL_ENTRIES)) nm = 10'(METAL_ENTRIES);
    ncur = pass_r ? nm : na;
  end

  logic [9:0] raddr;
  always_comb begin
    ara = AW'(raddr);
    mra = MW'(raddr);
  end
  logic signed [23:0] rd;
  assign rd = pass_r ? mrd_r : ard_r;

  logic [LW-1:0] mag;
  assign mag = lg_r[LW-1] ? LW'(-lg_r) : LW'(lg_r);

  logic signed [25:0] numd, dend;
  assign numd = 26'(x_r) - 26'(lo_r);
  assign dend = 26'(hi_r) - 26'(lo_r);
  logic [41:0] trial;
  assign trial = {rem_r, 1'b0} - {17'd0, den_r};

  assign q_ready = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);
  assign res_age_index = ai_r;
  assign res_metal_index = mi_r;
  assign res_aw_lo = aw1_r; assign res_aw_hi = aw2_r;
  assign res_mw_lo = mw1_r; assign res_mw_hi = mw2_r;

  // read address per phase: ends use ph_r, search uses k_r+1, then k_r for the lower entry
  always_comb begin
    raddr = k_r + 10'd1;
    if (st_r == S_ENDS || st_r == S_CLS) begin
      case (ph_r)
        2'd0: raddr = ncur - 10'd1;
        2'd1: raddr = pass_r ? 10'd0 : 10'd1;
        default: raddr = k_r;
      endcase
    end
    if (st_r == S_SRCHW && ph_r != 2'd0) raddr = k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          q_r <= q_data; pass_r <= 1'b0;
          if (q_data.age_pos) begin
            v_r <= q_data.age_val; st_r <= S_NORM;
          end else begin
            ai_r <= 8'd0; aw1_r <= 17'd0; aw2_r <= 17'd0; st_r <= S_NEXT;
          end
        end
        S_NORM: begin
          p_r <= msb;
          m_r <= (msb <= 6'd30) ? (v_r << (6'd30 - msb)) : (v_r >> (msb - 6'd30));
          f_r <= '0; it_r <= 6'd0; st_r <= S_SQR;
        end
        S_SQR: begin
          sq_r <= 64'(m_r) * 64'(m_r);
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          if (sq_r[61]) begin
            m_r <= 32'(sq_r >> 31); f_r <= {f_r[GB-2:0], 1'b1};
          end else begin
            m_r <= 32'(sq_r >> 30); f_r <= {f_r[GB-2:0], 1'b0};
          end
          it_r <= it_r + 6'd1;
          if (it_r == 6'(GB - 1)) st_r <= S_MUL;
          else st_r <= S_SQR;
        end
        S_MUL: begin
          lg_r <= $signed(LW'($signed({1'b0, p_r}) - (pass_r ? MetalFrac : TimeFrac))
                  <<< GB) + $signed(LW'({1'b0, f_r}));
          st_r <= S_RND;
          ph_r <= 2'd3;
        end
        S_RND: begin
          if (ph_r == 2'd3) begin
            prod_r <= PW'(mag) * PW'(Log10Two); ph_r <= 2'd2;
          end else begin
            x_r <= lg_r[LW-1] ?
              -25'((prod_r + (PW'(1) << (LS - 1))) >> LS) :
               25'((prod_r + (PW'(1) << (LS - 1))) >> LS);
            ph_r <= 2'd0; st_r <= S_ENDS;
          end
        end
        S_ENDS: begin  // issue read of last entry, then first
          if (ph_r == 2'd0) ph_r <= 2'd1;
          else begin
            hi_r <= rd; ph_r <= 2'd3; st_r <= S_CLS;   // last entry
          end
        end
        S_CLS: begin
          if (x_r > 25'(hi_r)) begin
            k_r <= ncur - 10'd2; fr_r <= WeightOne; st_r <= S_NEXT; ov_r <= 1'b1;
          end else if (x_r < 25'(rd)) begin
            k_r <= 10'd0; fr_r <= pass_r ? 17'd0 : WeightOne; st_r <= S_NEXT;
            ov_r <= 1'b1;
          end else begin
            k_r <= pass_r ? 10'd0 : 10'd1; ph_r <= 2'd0; st_r <= S_SRCH; ov_r <= 1'b0;
          end
        end
        S_SRCH: st_r <= S_SRCHW;        // read k+1
        S_SRCHW: begin
          if (ph_r == 2'd0) begin
            if (k_r < ncur - 10'd2 && rd < 25'(x_r) && $signed(rd) < x_r) begin
              k_r <= k_r + 10'd1; st_r <= S_SRCH;
            end else begin
              hi_r <= rd; ph_r <= 2'd1;
            end
          end else if (ph_r == 2'd1) begin
            ph_r <= 2'd2;               // read k issued
          end else begin
            lo_r <= rd;
            st_r <= S_DIV; dc_r <= 5'd0;
          end
        end
        S_DIV: begin
          if (dc_r == 5'd0) begin
            if (dend <= 0 || numd <= 0) begin
              fr_r <= 17'd0; st_r <= S_NEXT;
            end else if (numd >= dend) begin
              fr_r <= WeightOne; st_r <= S_NEXT;
            end else begin
              rem_r <= 41'(numd); den_r <= 25'(dend); fr_r <= '0; dc_r <= 5'd1;
            end
          end else begin
            if (!trial[41]) begin
              rem_r <= trial[40:0]; fr_r <= {fr_r[15:0], 1'b1};
            end else begin
              rem_r <= {rem_r[39:0], 1'b0}; fr_r <= {fr_r[15:0], 1'b0};
            end
            if (dc_r == 5'd16) st_r <= S_NEXT;
            dc_r <= dc_r + 5'd1;
          end
        end
        S_NEXT: begin
          if (!pass_r) begin
            if (q_r.age_pos) begin
              ai_r <= 8'(k_r);
              aw1_r <= ov_r ? 17'd0 : WeightOne - fr_r;
              aw2_r <= ov_r ? WeightOne : fr_r;
            end
            pass_r <= 1'b1;
            if (q_r.met_nz) begin
              v_r <= {8'd0, q_r.met_val}; st_r <= S_NORM;
            end else begin
              mi_r <= 3'd0; mw1_r <= WeightOne; mw2_r <= 17'd0; st_r <= S_OUT;
            end
          end else begin
            mi_r <= 3'(k_r);
            mw1_r <= WeightOne - fr_r; mw2_r <= fr_r;
            st_r <= S_OUT;
          end
        end
        S_OUT: if (res_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/table_bracket_interp_weights_unit.sv =====
// Per table in use, a query goes through the log pass and, when it falls inside the
// table, the bracket search and divider. The back end takes one query at a time; a
// load is accepted once no query is queued or in the back end.
// Reset: synchronous active-low rst_n clears control registers and sets the age
// and metal count registers to 256 and 8; table contents are undefined until
// written.
// ---------------------------------------------------------------------------
// table_bracket_interp_weights_unit: top level
// Front end with load path and query queue, back end computing weights.
// ---------------------------------------------------------------------------
module table_bracket_interp_weights_unit #(
  parameter int AGE_ENTRIES   = tbiw_pkg::AgeEntriesDef,
  parameter int METAL_ENTRIES = tbiw_pkg::MetalEntriesDef,
  parameter int FRAC_BITS     = tbiw_pkg::FracBitsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // kind
  input  logic [119:0] in_tdata,   // entry_index, entry_value, time_now, time_target, metallicity
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,  // age_index, metal_index, age_w_lo, age_w_hi, met_w_lo, met_w_hi
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [8:0]   cfg_data
);
  import tbiw_pkg::*;
  localparam int AW = $clog2(AGE_ENTRIES);
  localparam int MW = $clog2(METAL_ENTRIES);

  logic [8:0] age_count_r;
  logic [3:0] metal_count_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_count_r <= 9'd256; metal_count_r <= 4'd8;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_AGE_COUNT) age_count_r <= cfg_data;
      if (cfg_index == CFG_METAL_COUNT) metal_count_r <= cfg_data[3:0];
    end
  end

  logic age_we, met_we, q_valid, q_ready;
  logic [AW-1:0] age_wa;
  logic [MW-1:0] met_wa;
  logic signed [23:0] wr_data;
  query_t q_data;

  // result registers live in the back end
  logic        rv;
  logic [7:0]  ai; logic [2:0] mi;
  logic [16:0] a1, a2, m1, m2;

  tbiw_front #(.AGE_ENTRIES(AGE_ENTRIES), .METAL_ENTRIES(METAL_ENTRIES)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .kind(in_tuser),
    .entry_index(in_tdata[7:0]), .entry_value(in_tdata[31:8]),
    .time_now(in_tdata[63:32]), .time_target(in_tdata[95:64]),
    .metallicity(in_tdata[119:96]),
    .age_we, .age_wa, .met_we, .met_wa, .wr_data, .q_valid, .q_ready, .q_data);

  tbiw_back #(.AGE_ENTRIES(AGE_ENTRIES), .METAL_ENTRIES(METAL_ENTRIES),
    .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data, .age_we, .age_wa, .met_we, .met_wa,
    .wr_data, .age_count(age_count_r), .metal_count(metal_count_r),
    .res_valid(rv), .res_ready(out_tready), .res_age_index(ai), .res_metal_index(mi),
    .res_aw_lo(a1), .res_aw_hi(a2), .res_mw_lo(m1), .res_mw_hi(m2));

  assign out_tvalid = rv;
  assign out_tdata  = {9'd0, m2, m1, a2, a1, mi, ai};

`ifndef SYNTHESIS
  a_wsum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (18'(out_tdata[78:62]) + 18'(out_tdata[61:45]) == 18'h10000))
    else $error("metal weights");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");
`endif
endmodule

// ===== bench/table_bracket_interp_weights_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// table_bracket_interp_weights_unit_test: self-checking bench
// Loads age and metallicity tables, runs directed and random queries under
// several count settings and flow-control patterns, and compares each weight
// transaction with a bit-accurate prediction computed in the bench.
// ---------------------------------------------------------------------------
module table_bracket_interp_weights_unit_test;
  import tbiw_pkg::*;

  typedef struct packed {
    logic [8:0]  pad;
    logic [16:0] met_w_hi;
    logic [16:0] met_w_lo;
    logic [16:0] age_w_hi;
    logic [16:0] age_w_lo;
    logic [2:0]  met_idx;
    logic [7:0]  age_idx;
  } weights_t;

  localparam logic [1:0] KIND_NONE = 2'd3;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [1:0]   in_tuser;
  logic [119:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [87:0]  out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [8:0]   cfg_data;

  int           age_tbl[256];
  int           met_tbl[8];
  logic [8:0]   age_cnt;
  logic [3:0]   met_cnt;
  weights_t     weights_pending[$];
  int           mismatches;
  int           send_idle_pct;
  int           recv_stall_pct;

  table_bracket_interp_weights_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  initial begin
    #400_000_000;
    $display("Mismatches found");
    $finish;
  end

  // log10 of v with in_frac input fraction bits, result in Q8.16
  function automatic longint log10_fixed(longint unsigned v, int in_frac);
    int p;
    longint unsigned m, f, mag, r;
    longint lg;
    p = 0;
    f = 0;
    for (int i = 0; i < 64; i++) if (v[i]) p = i;
    m = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
    for (int i = 0; i < 20; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        f = f | 64'd1;
      end
    end
    lg = longint'(p - in_frac) * 64'sd1048576 + longint'(f);
    mag = (lg < 0) ? longint'(-lg) : longint'(lg);
    r = (mag * 64'd1292913986 + (64'd1 << 35)) >> 36;
    return (lg < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned upper_weight(longint x, longint lo, longint hi);
    longint num, den;
    num = x - lo;
    den = hi - lo;
    if (den <= 0 || num <= 0) return 0;
    if (num >= den) return 65536;
    return longint'((num * 65536) / den);
  endfunction

  function automatic weights_t predict_weights(logic [31:0] t_now, logic [31:0] t_tgt,
                                               logic [23:0] met);
    weights_t w;
    int na, nm, k;
    longint a, z;
    longint unsigned fr;
    w = '0;
    na = int'(age_cnt);
    if (na < 3) na = 3;
    if (na > 256) na = 256;
    nm = int'(met_cnt);
    if (nm < 2) nm = 2;
    if (nm > 8) nm = 8;
    if (t_now > t_tgt) begin
      a = log10_fixed({32'd0, t_now - t_tgt}, TimeFrac);
      if (a > age_tbl[na-1]) begin
        w.age_idx = 8'(na - 2);
        w.age_w_hi = WeightOne;
      end else if (a < age_tbl[1]) begin
        w.age_w_hi = WeightOne;
      end else begin
        k = 1;
        while (k < na - 2 && age_tbl[k+1] < a) k++;
        fr = upper_weight(a, age_tbl[k], age_tbl[k+1]);
        w.age_idx = 8'(k);
        w.age_w_lo = 17'(65536 - fr);
        w.age_w_hi = 17'(fr);
      end
    end
    if (met == 0) begin
      w.met_w_lo = WeightOne;
    end else begin
      z = log10_fixed({40'd0, met}, MetalFrac);
      if (z > met_tbl[nm-1]) begin
        w.met_idx = 3'(nm - 2);
        w.met_w_hi = WeightOne;
      end else if (z < met_tbl[0]) begin
        w.met_w_lo = WeightOne;
      end else begin
        k = 0;
        while (k < nm - 2 && met_tbl[k+1] < z) k++;
        fr = upper_weight(z, met_tbl[k], met_tbl[k+1]);
        w.met_idx = 3'(k);
        w.met_w_lo = 17'(65536 - fr);
        w.met_w_hi = 17'(fr);
      end
    end
    return w;
  endfunction

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    weights_t got, exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (weights_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected weight transaction %h", out_tdata);
      end else begin
        exp_w = weights_pending.pop_front();
        if (got.age_idx !== exp_w.age_idx || got.met_idx !== exp_w.met_idx ||
            got.age_w_lo !== exp_w.age_w_lo || got.age_w_hi !== exp_w.age_w_hi ||
            got.met_w_lo !== exp_w.met_w_lo || got.met_w_hi !== exp_w.met_w_hi ||
            got.pad !== exp_w.pad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("weights mismatch: exp ai=%0d mi=%0d aw=%0d/%0d mw=%0d/%0d pad=%h",
                     exp_w.age_idx, exp_w.met_idx, exp_w.age_w_lo, exp_w.age_w_hi,
                     exp_w.met_w_lo, exp_w.met_w_hi, exp_w.pad);
            $display("                  got ai=%0d mi=%0d aw=%0d/%0d mw=%0d/%0d pad=%h",
                     got.age_idx, got.met_idx, got.age_w_lo, got.age_w_hi,
                     got.met_w_lo, got.met_w_hi, got.pad);
          end
        end
      end
    end
  end

  task automatic send_item(logic [1:0] kind, logic [7:0] idx, logic [23:0] val,
                           logic [31:0] t_now, logic [31:0] t_tgt, logic [23:0] met);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {met, t_tgt, t_now, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (kind)
      KIND_QUERY: weights_pending.push_back(predict_weights(t_now, t_tgt, met));
      KIND_AGE: age_tbl[idx] = $signed(val);
      KIND_METAL: if (idx < 8) met_tbl[idx] = $signed(val);
      default: ;
    endcase
  endtask

  // wait out every pending transaction plus the worst query latency
  task automatic drain();
    in_tvalid <= 1'b0;
    while (weights_pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_reg(logic index, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (index == CFG_AGE_COUNT) age_cnt = data;
    else met_cnt = data[3:0];
  endtask

  // ascending tables over the entries in use, spread over the useful log range;
  // some flat steps, optionally scrambled to exercise unordered brackets
  task automatic load_tables(bit scrambled);
    int n, m, v, step;
    n = (age_cnt < 3) ? 3 : (age_cnt > 256 ? 256 : age_cnt);
    m = (met_cnt < 2) ? 2 : (met_cnt > 8 ? 8 : met_cnt);
    v = -360000 + $urandom_range(0, 40000);
    step = 700000 / (n - 1);
    for (int i = 0; i < n; i++) begin
      send_item(KIND_AGE, 8'(i),
                scrambled ? 24'($urandom_range(0, 2000000) - 1000000) : 24'(v),
                $urandom, $urandom, 24'($urandom));
      if ($urandom_range(9) != 0) v += $urandom_range(step / 2, step * 3 / 2 + 1);
    end
    v = -520000 + $urandom_range(0, 60000);
    step = 540000 / (m - 1);
    for (int i = 0; i < m; i++) begin
      send_item(KIND_METAL, 8'(i),
                scrambled ? 24'($urandom_range(0, 1000000) - 800000) : 24'(v),
                $urandom, $urandom, 24'($urandom));
      if ($urandom_range(7) != 0) v += $urandom_range(step / 2, step * 3 / 2 + 1);
    end
    // out-of-range metallicity positions are dropped
    send_item(KIND_METAL, 8'($urandom_range(8, 255)), 24'($urandom), $urandom, $urandom,
              24'($urandom));
    drain();
  endtask

  task automatic send_query();
    logic [31:0] t_tgt, diff, t_now;
    logic [23:0] met;
    t_tgt = $urandom;
    diff = $urandom >> $urandom_range(0, 31);
    if ($urandom_range(9) == 0) t_now = t_tgt - diff;
    else if (t_tgt > 32'hFFFF_FFFF - diff) begin
      t_now = t_tgt;
      t_tgt = t_now - diff;
    end else t_now = t_tgt + diff;
    met = ($urandom_range(19) == 0) ? 24'd0 : 24'($urandom >> $urandom_range(8, 31));
    if (met == 0 && $urandom_range(1)) met = 24'($urandom);
    if ($urandom_range(24) == 0) send_item(KIND_NONE, 8'($urandom), 24'($urandom),
                                           $urandom, $urandom, 24'($urandom));
    send_item(KIND_QUERY, 8'($urandom), 24'($urandom), t_now, t_tgt, met);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_tables(0);
    send_item(KIND_QUERY, 8'hFF, 24'hFFFFFF, 32'd5, 32'd5, 24'd0);
    send_item(KIND_QUERY, 8'h00, 24'h000000, 32'd0, 32'hFFFF_FFFF, 24'hFFFFFF);
    send_item(KIND_QUERY, 8'hAA, 24'h555555, 32'd1, 32'd0, 24'd1);
    send_item(KIND_QUERY, 8'h55, 24'hAAAAAA, 32'hFFFF_FFFF, 32'd0, 24'h800000);
    send_item(KIND_QUERY, 8'h00, 24'h0, 32'h0001_0000, 32'd0, 24'h19999A);
    send_item(KIND_QUERY, 8'h00, 24'h0, 32'h0010_0000, 32'h0000_8000, 24'h000400);
    send_item(KIND_NONE, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF, 32'd0, 24'hFFFFFF);
    drain();
    // extreme table values: everything falls between them
    send_item(KIND_AGE, 8'd1, 24'h800000, 32'd0, 32'd0, 24'd0);
    send_item(KIND_AGE, 8'd2, 24'h7FFFFF, 32'd0, 32'd0, 24'd0);
    send_item(KIND_METAL, 8'd0, 24'h800000, 32'd0, 32'd0, 24'd0);
    send_item(KIND_METAL, 8'd1, 24'h7FFFFF, 32'd0, 32'd0, 24'd0);
    drain();
    write_reg(CFG_AGE_COUNT, 9'd3);
    write_reg(CFG_METAL_COUNT, 9'd2);
    send_item(KIND_QUERY, 8'h0, 24'h0, 32'h0000_0003, 32'd0, 24'h000001);
    send_item(KIND_QUERY, 8'h0, 24'h0, 32'hFFFF_0000, 32'd7, 24'hFFFFFF);
    drain();
    write_reg(CFG_AGE_COUNT, 9'd0);
    write_reg(CFG_METAL_COUNT, 9'h1F0);
    load_tables(0);
    for (int i = 0; i < 6; i++) send_query();
    drain();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, logic [8:0] n_age,
                                   logic [8:0] n_met, bit scrambled, int queries);
    write_reg(CFG_AGE_COUNT, n_age);
    write_reg(CFG_METAL_COUNT, n_met);
    load_tables(scrambled);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < queries; i++) send_query();
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = KIND_QUERY;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_AGE_COUNT;
    cfg_data = '0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    age_cnt = 9'd256;
    met_cnt = 4'd8;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(0, 0, 9'd256, 9'd8, 0, 175);
    test_random_phase(79, 0, 9'd3, 9'd2, 0, 150);
    test_random_phase(0, 79, 9'($urandom_range(3, 256)), 9'($urandom_range(2, 8)), 0, 175);
    test_random_phase(36, 36, 9'd17, 9'd5, 1, 150);
    test_random_phase(0, 0, 9'd511, 9'd15, 0, 125);
    test_random_phase(36, 36, 9'($urandom_range(3, 64)), 9'($urandom_range(2, 8)), 0, 225);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tbiw_pkg.sv
src/tbiw_front.sv
src/tbiw_back.sv
src/table_bracket_interp_weights_unit.sv
bench/table_bracket_interp_weights_unit_test.sv
